// ----- sv/beckmann_density_and_pdf_core_defines.svh -----
// Assertion helpers for the core RTL file.
`ifndef BECKMANN_DENSITY_AND_PDF_CORE_DEFINES_SVH
`define BECKMANN_DENSITY_AND_PDF_CORE_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define BDP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define BDP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/bdp_pkg.sv -----
package bdp_pkg;

  // Fixed-point constants
  localparam logic [30:0] ONE_Q30       = 31'h4000_0000;
  localparam logic [30:0] LOG2E_Q30     = 31'd1549082005;
  localparam logic [30:0] INV_PI_Q32    = 31'd1367130551;
  localparam logic [20:0] EXP_LIMIT_Q16 = 21'd1507328;
  localparam logic [31:0] SAT32         = 32'hFFFF_FFFF;
  localparam logic [16:0] M_MAX         = 17'h1_0000;
  localparam logic [16:0] M_MIN         = 17'h0_0001;

  // Register map
  localparam logic [2:0] ADDR_ROUGHNESS = 3'd0;

  // Integer square root, two bits per step
  function automatic logic [63:0] isqrt64(logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Entry j of the power table: 2^(-2^-j) in Q0.32
  function automatic logic [31:0] exp_tab(int unsigned j);
    logic [63:0] e;
    e = 64'h8000_0000;
    for (int unsigned i = 1; i <= j; i++) begin
      e = isqrt64(e << 32);
    end
    return e[31:0];
  endfunction

endpackage

// ----- sv/bdp_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
module bdp_div #(
  parameter int NW = 63,
  parameter int DW = 47,
  parameter int QW = 21,
  parameter int TW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_v,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [TW-1:0] tag_in,
  output logic          out_v,
  output logic [QW-1:0] quot,
  output logic          ovf,
  output logic [TW-1:0] tag_out
);

  localparam int RW = ((NW > DW + QW) ? NW : DW + QW) + 1;

  logic          v   [0:QW];
  logic [RW-1:0] rem [0:QW-1];
  logic [DW-1:0] dv  [0:QW-1];
  logic [QW-1:0] q   [0:QW];
  logic          ov  [0:QW];
  logic [TW-1:0] tg  [0:QW];

  // Load and check that the quotient fits
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= RW'(num);
      dv[0]  <= den;
      q[0]   <= '0;
      ov[0]  <= RW'(num) >= (RW'(den) << QW);
      tg[0]  <= tag_in;
    end
  end

  // One trial subtract per stage, highest bit first
  for (genvar i = 1; i <= QW; i++) begin : g_bit
    localparam int B = QW - i;
    logic [RW-1:0] shifted;
    logic          fits;

    assign shifted = RW'(dv[i-1]) << B;
    assign fits    = rem[i-1] >= shifted;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i] <= 1'b0;
      end else if (en) begin
        v[i] <= v[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q[i]  <= fits ? (q[i-1] | (QW'(1) << B)) : q[i-1];
        ov[i] <= ov[i-1];
        tg[i] <= tg[i-1];
      end
    end

    if (i < QW) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem[i] <= fits ? rem[i-1] - shifted : rem[i-1];
          dv[i]  <= dv[i-1];
        end
      end
    end
  end

  assign out_v   = v[QW];
  assign quot    = q[QW];
  assign ovf     = ov[QW];
  assign tag_out = tg[QW];

endmodule

// ----- sv/beckmann_density_and_pdf_core.sv -----
// Beckmann microfacet density and sampling pdf. Takes one query word per clock
// while the output buffer is not full and returns one result word per query, in
// order. The pipeline depth is set by the pipelined restoring dividers (21
// quotient bits for the exponent, 32 for each of the two final quotients, one
// bit per stage) and the 16 multiply stages of the power-of-two evaluation. A
// two-word output buffer lets the input keep flowing while a result waits; the
// pipeline freezes only when both words are held. Roughness is written at byte
// address 0 and must only be changed while no query is in flight.
`include "beckmann_density_and_pdf_core_defines.svh"

module beckmann_density_and_pdf_core (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // query
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] normal_x,
  input  logic signed [31:0] normal_y,
  input  logic signed [31:0] normal_z,
  input  logic signed [31:0] half_x,
  input  logic signed [31:0] half_y,
  input  logic signed [31:0] half_z,
  // result
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        density,
  output logic [31:0]        sample_pdf,
  output logic               below_horizon,
  output logic               clipped
);

  typedef struct packed {
    logic [32:0] e;
    logic [15:0] f;
    logic [5:0]  k;
    logic        zero;
    logic        below;
    logic [30:0] c3;
    logic [30:0] c4;
  } exp_stage_t;

  typedef struct packed {
    logic [31:0] density;
    logic [31:0] sample_pdf;
    logic        below;
    logic        clipped;
  } result_t;

  // Configuration register
  logic [16:0] roughness;
  logic [16:0] m_cl;
  logic [33:0] m_sq;
  logic [32:0] m2;

  always_ff @(posedge clk) begin
    if (rst) begin
      roughness <= bdp_pkg::M_MAX;
    end else if (psel && penable && pwrite && paddr == bdp_pkg::ADDR_ROUGHNESS) begin
      roughness <= pwdata[16:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == bdp_pkg::ADDR_ROUGHNESS) ? {15'b0, roughness} : '0;

  // Clamp roughness and square it
  always_comb begin
    if (roughness < bdp_pkg::M_MIN) begin
      m_cl = bdp_pkg::M_MIN;
    end else if (roughness > bdp_pkg::M_MAX) begin
      m_cl = bdp_pkg::M_MAX;
    end else begin
      m_cl = roughness;
    end
  end

  assign m_sq = m_cl * m_cl;

  always_ff @(posedge clk) begin
    m2 <= m_sq[32:0];
  end

  // Pipeline advance: freeze while the output buffer is full
  logic skid_v;
  logic adv;

  assign adv      = !skid_v;
  assign in_ready = adv;

  // Stage 1: per-axis products
  logic               v1;
  logic signed [63:0] p_x, p_y, p_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_x <= normal_x * half_x;
      p_y <= normal_y * half_y;
      p_z <= normal_z * half_z;
    end
  end

  // Stage 2: sum, clamp, take magnitude
  logic               v2;
  logic signed [35:0] c_sum;
  logic signed [35:0] c_abs;
  logic [30:0]        a_next;
  logic [30:0]        a2;
  logic               below2;

  assign c_sum = 36'(p_x >>> 30) + 36'(p_y >>> 30) + 36'(p_z >>> 30);
  assign c_abs = c_sum[35] ? -c_sum : c_sum;
  assign a_next = (c_abs > 36'sd1073741824) ? bdp_pkg::ONE_Q30 : c_abs[30:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a2     <= a_next;
      below2 <= c_sum[35];
    end
  end

  // Stage 3: cosine squared
  logic        v3;
  logic [61:0] aa;
  logic [30:0] c2_3;
  logic [30:0] a3;
  logic        below3;

  assign aa = a2 * a2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c2_3   <= aa[60:30];
      a3     <= a2;
      below3 <= below2;
    end
  end

  // Stage 4: cube, fourth power, exponent divisor, sine squared
  logic        v4;
  logic [61:0] c3_prod;
  logic [61:0] c4_prod;
  logic [63:0] t_prod;
  logic [30:0] c3_4, c4_4, s2_4;
  logic [46:0] t4;
  logic        below4;

  assign c3_prod = c2_3 * a3;
  assign c4_prod = c2_3 * c2_3;
  assign t_prod  = c2_3 * m2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c3_4   <= c3_prod[60:30];
      c4_4   <= c4_prod[60:30];
      t4     <= t_prod[62:16];
      s2_4   <= bdp_pkg::ONE_Q30 - c2_3;
      below4 <= below3;
    end
  end

  // Exponent x = (s2 << 32) / t
  logic        vx;
  logic [20:0] xq;
  logic        x_ovf;
  logic [62:0] x_tag;

  bdp_div #(
    .NW(63),
    .DW(47),
    .QW(21),
    .TW(63)
  ) u_xdiv (
    .clk    (clk),
    .rst    (rst),
    .en     (adv),
    .in_v   (v4),
    .num    ({s2_4, 32'b0}),
    .den    (t4),
    .tag_in ({c3_4, c4_4, below4}),
    .out_v  (vx),
    .quot   (xq),
    .ovf    (x_ovf),
    .tag_out(x_tag)
  );

  // Stage Y: scale to base two, split integer and fraction
  logic       ex_v [0:16];
  exp_stage_t ex   [0:16];
  logic [51:0] y_prod;

  assign y_prod = xq * bdp_pkg::LOG2E_Q30;

  always_ff @(posedge clk) begin
    if (rst) begin
      ex_v[0] <= 1'b0;
    end else if (adv) begin
      ex_v[0] <= vx;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ex[0].e     <= 33'h1_0000_0000;
      ex[0].f     <= y_prod[45:30];
      ex[0].k     <= y_prod[51:46];
      ex[0].zero  <= x_ovf || (xq >= bdp_pkg::EXP_LIMIT_Q16);
      ex[0].c3    <= x_tag[62:32];
      ex[0].c4    <= x_tag[31:1];
      ex[0].below <= x_tag[0];
    end
  end

  // One table multiply per fraction bit, highest first
  for (genvar j = 1; j <= 16; j++) begin : g_exp
    localparam logic [31:0] TAB = bdp_pkg::exp_tab(j);
    logic [64:0] ep;
    exp_stage_t  ex_next;

    assign ep = ex[j-1].e * TAB;

    always_comb begin
      ex_next = ex[j-1];
      if (ex[j-1].f[16-j]) begin
        ex_next.e = ep[64:32];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        ex_v[j] <= 1'b0;
      end else if (adv) begin
        ex_v[j] <= ex_v[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        ex[j] <= ex_next;
      end
    end
  end

  // Stage SH: integer shift and denominators
  logic        vs;
  logic [32:0] e_sh;
  logic [63:0] dd_prod;
  logic [63:0] dp_prod;
  logic [63:0] den_d, den_p;
  logic        below_s;

  assign dd_prod = m2 * ex[16].c4;
  assign dp_prod = m2 * ex[16].c3;

  always_ff @(posedge clk) begin
    if (rst) begin
      vs <= 1'b0;
    end else if (adv) begin
      vs <= ex_v[16];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_sh    <= ex[16].zero ? '0 : (ex[16].e >> ex[16].k);
      den_d   <= dd_prod;
      den_p   <= dp_prod;
      below_s <= ex[16].below;
    end
  end

  // Stage N: numerator
  logic        vn;
  logic [63:0] num_prod;
  logic [62:0] num_n;
  logic [63:0] den_dn, den_pn;
  logic        below_n;
  logic        e0_n;

  assign num_prod = e_sh * bdp_pkg::INV_PI_Q32;

  always_ff @(posedge clk) begin
    if (rst) begin
      vn <= 1'b0;
    end else if (adv) begin
      vn <= vs;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num_n   <= num_prod[62:0];
      den_dn  <= den_d;
      den_pn  <= den_p;
      below_n <= below_s;
      e0_n    <= (e_sh == '0);
    end
  end

  // Final quotients in Q16.16
  logic        vd, vp;
  logic [31:0] qd, qp;
  logic        ovf_d, ovf_p;
  logic        e0_d;
  logic        below_p;

  bdp_div #(
    .NW(77),
    .DW(64),
    .QW(32),
    .TW(1)
  ) u_ddiv (
    .clk    (clk),
    .rst    (rst),
    .en     (adv),
    .in_v   (vn),
    .num    ({num_n, 14'b0}),
    .den    (den_dn),
    .tag_in (e0_n),
    .out_v  (vd),
    .quot   (qd),
    .ovf    (ovf_d),
    .tag_out(e0_d)
  );

  bdp_div #(
    .NW(77),
    .DW(64),
    .QW(32),
    .TW(1)
  ) u_pdiv (
    .clk    (clk),
    .rst    (rst),
    .en     (adv),
    .in_v   (vn),
    .num    ({num_n, 14'b0}),
    .den    (den_pn),
    .tag_in (below_n),
    .out_v  (vp),
    .quot   (qp),
    .ovf    (ovf_p),
    .tag_out(below_p)
  );

  // Saturate and zero the special cases
  result_t res;
  logic    push;

  always_comb begin
    res.below      = below_p;
    res.density    = e0_d ? '0 : (ovf_d ? bdp_pkg::SAT32 : qd);
    res.sample_pdf = (e0_d || below_p) ? '0 : (ovf_p ? bdp_pkg::SAT32 : qp);
    res.clipped    = !e0_d && (ovf_d || (!below_p && ovf_p));
  end

  assign push = adv && vd && vp;

  // Output register plus skid word
  result_t out_r;
  result_t skid_r;
  logic    out_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (!out_v || out_ready) begin
      if (skid_v) begin
        out_v  <= 1'b1;
        out_r  <= skid_r;
        skid_v <= 1'b0;
      end else begin
        out_v <= push;
        if (push) begin
          out_r <= res;
        end
      end
    end else if (push) begin
      skid_v <= 1'b1;
      skid_r <= res;
    end
  end

  assign out_valid     = out_v;
  assign density       = out_r.density;
  assign sample_pdf    = out_r.sample_pdf;
  assign below_horizon = out_r.below;
  assign clipped       = out_r.clipped;

  `BDP_ASSERT_IMPL(a_skid_has_out, skid_v, out_v, "skid word held without output word")
  `BDP_ASSERT_NEXT(a_skid_kept, skid_v && !out_ready, skid_v, "skid word dropped")
  `BDP_ASSERT_IMPL(a_below_pdf_zero, out_v && out_r.below, out_r.sample_pdf == '0, "pdf not zero below horizon")
  `BDP_ASSERT_IMPL(a_clip_sat, out_v && out_r.clipped, (out_r.density == bdp_pkg::SAT32) || (out_r.sample_pdf == bdp_pkg::SAT32), "clip flag without saturated result")

endmodule
